// File: rtl/ovle_pkg.sv
// ovle_pkg: shared types and constants of the ordered value list engine
`timescale 1ns / 1ps

package ovle_pkg;

  localparam int DATA_W     = 32;
  localparam int POS_W      = 6;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W  = OUT_TDATA_W - POS_W - DATA_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5,
    ST_LISTED    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;
    logic              last;
  } res_t;

endpackage

// File: rtl/ovle_ram.sv
// ovle_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module ovle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ovle_ctrl.sv
// ovle_ctrl: sequencer that walks the entry store with one shared compare unit
`timescale 1ns / 1ps

module ovle_ctrl
  import ovle_pkg::*;
#(
  parameter int CAPACITY = 32,
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  in_cmd_i,
  input  logic [DATA_W-1:0] in_value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [DATA_W-1:0] ram_wdata_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [DATA_W-1:0] ram_rdata_i
);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [DATA_W-1:0] opv_q, opv_d;
  logic              del_q, del_d;
  res_t              res_q, res_d;

  logic [CW-1:0]     cur_inc;
  logic              at_end;
  logic              match;

  // shared compare unit: entry value against operand, and index against fill
  assign cur_inc = CW'(cur_q) + CW'(1);
  assign at_end  = (cur_inc == count_q);
  assign match   = (ram_rdata_i == opv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    opv_q <= opv_d;
    del_q <= del_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    opv_d       = opv_q;
    del_d       = del_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(count_q);
    ram_wdata_o = in_value_i;
    ram_raddr_o = cur_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ram_raddr_o = '0;
        if (in_valid_i) begin
          opv_d            = in_value_i;
          del_d            = (cmd_e'(in_cmd_i) == CMD_DELETE);
          cur_d            = '0;
          res_d.position   = '0;
          res_d.item_value = '0;
          res_d.last       = 1'b1;
          if (cmd_e'(in_cmd_i) == CMD_INSERT) begin
            state_d = S_RESP;
            if (count_q == CW'(CAPACITY)) begin
              res_d.status = ST_FULL;
            end else begin
              ram_we_o     = 1'b1;
              count_d      = count_q + CW'(1);
              res_d.status = ST_INSERTED;
            end
          end else if (count_q == '0) begin
            res_d.status = ST_EMPTY;
            state_d      = S_RESP;
          end else if (cmd_e'(in_cmd_i) == CMD_LIST) begin
            state_d = S_LIST;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read data belongs to cur_q, next address issued ahead
        ram_raddr_o = cur_q + AW'(1);
        cur_d       = cur_q + AW'(1);
        if (match) begin
          if (del_q) begin
            if (at_end) begin
              count_d      = count_q - CW'(1);
              res_d.status = ST_DELETED;
              state_d      = S_RESP;
            end else begin
              state_d = S_SHIFT;
            end
          end else begin
            res_d.status     = ST_FOUND;
            res_d.position   = POS_W'(cur_inc);
            res_d.item_value = ram_rdata_i;
            state_d          = S_RESP;
          end
        end else if (at_end) begin
          res_d.status = ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end

      S_SHIFT: begin
        // move entry cur_q up one place
        ram_we_o    = 1'b1;
        ram_waddr_o = cur_q - AW'(1);
        ram_wdata_o = ram_rdata_i;
        ram_raddr_o = cur_q + AW'(1);
        cur_d       = cur_q + AW'(1);
        if (at_end) begin
          count_d      = count_q - CW'(1);
          res_d.status = ST_DELETED;
          state_d      = S_RESP;
        end
      end

      S_LIST: begin
        res_valid_o      = 1'b1;
        res_o.status     = ST_LISTED;
        res_o.position   = POS_W'(cur_inc);
        res_o.item_value = ram_rdata_i;
        res_o.last       = at_end;
        if (res_ready_i) begin
          if (at_end) begin
            state_d = S_IDLE;
          end else begin
            ram_raddr_o = cur_q + AW'(1);
            cur_d       = cur_q + AW'(1);
          end
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ordered_value_list_engine.sv
// ordered_value_list_engine: top level of the ordered value list engine
//
//  channel   | dir | tdata                         | tuser       | tlast
//  ----------+-----+-------------------------------+-------------+-------------
//  s_axis    | in  | [31:0] value                  | [1:0] cmd   | unused
//  m_axis    | out | [5:0] position, [37:6] value  | [2:0] status| final result
//
//  walks: insert and empty-list requests do not walk the store; search and delete walk
//    the store one entry a cycle through the single read port; a delete moves the
//    later entries up in the cycles the rest of the walk would use, so it always
//    walks to the last entry; list all gives one result a cycle while the output
//    register accepts it
//  reset: rst_ni clears the fill count and the sequencer, the store is not
//    cleared and holds no meaning until written
//  stalls: a result waits in the output register while the sequencer goes on;
//    with that register full and m_axis_tready low, list all and the final
//    response hold in place and s_axis_tready stays low
`timescale 1ns / 1ps

module ordered_value_list_engine
  import ovle_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,  // [31:0] value
  input  logic [CMD_W-1:0]       s_axis_tuser,  // [1:0] command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [5:0] position, [37:6] item_value, pad
  output logic [STATUS_W-1:0]    m_axis_tuser,  // [2:0] status
  output logic                   m_axis_tlast   // final_result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;

  // sequencer with the shared compare unit
  ovle_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // compacted entry store, oldest entry at address zero
  ovle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_q.item_value, out_res_q.position};
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tlast  = out_res_q.last;

endmodule
